>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the node update block.
// Expand to concurrent assertions in simulation and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define EIK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Consequent checked in the cycle after the antecedent.
`define EIK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EIK_ASSERT(label, clk, rst_n, prop)
`define EIK_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/eik_pkg.sv
// Shared types and constants of the Eikonal node update block.
// No dependencies.
package eik_pkg;

  localparam int VB = 32;
  localparam int FB = 16;
  localparam logic [VB-1:0] VINF = '1;

  localparam logic [1:0] KIND_SOLVE = 2'd0;
  localparam logic [1:0] KIND_FIXED = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  typedef struct packed {
    logic        [VB-1:0] current_u;
    logic        [VB-1:0] inverse_speed;
    logic        [VB-1:0] left_value;
    logic signed [VB-1:0] left_dist;
    logic        [VB-1:0] right_value;
    logic signed [VB-1:0] right_dist;
    logic        [VB-1:0] down_value;
    logic signed [VB-1:0] down_dist;
    logic        [VB-1:0] up_value;
    logic signed [VB-1:0] up_dist;
  } eik_in_t;

  typedef struct packed {
    logic [VB-1:0] new_u;
    logic [VB-1:0] decrease;
  } eik_out_t;

  // Classified node: sorted axes, spacings and axis difference.
  typedef struct packed {
    logic [1:0]    kind;
    logic [VB-1:0] cur;
    logic [VB-1:0] f;
    logic [VB-1:0] a0;
    logic [VB-1:0] h0;
    logic [VB-1:0] a1;
    logic [VB-1:0] h1;
    logic [VB-1:0] d;
  } eik_item_t;

endpackage

>>> rtl/eik_front.sv
// Front end: picks the upwind neighbor per axis, sorts the axes, classifies the node.
// Depends on eik_pkg.
module eik_front import eik_pkg::*; (
  input  eik_in_t   in_data,
  output eik_item_t item
);

  logic [VB-1:0] ax_v, ax_h, ay_v, ay_h;
  logic          swap;

  function automatic logic [2*VB-1:0] pick_axis(input logic [VB-1:0] mv, md, pv, pd);
    logic mw, pw;
    mw = md[VB-1];
    pw = pd[VB-1];
    if (mw && pw) begin
      pick_axis = {VINF, {VB{1'b0}}};
    end else if (mw || (!pw && !(mv < pv))) begin
      pick_axis = {pv, pd};
    end else begin
      pick_axis = {mv, md};
    end
  endfunction

  always_comb begin
    {ax_v, ax_h} = pick_axis(in_data.left_value, in_data.left_dist,
                             in_data.right_value, in_data.right_dist);
    {ay_v, ay_h} = pick_axis(in_data.down_value, in_data.down_dist,
                             in_data.up_value, in_data.up_dist);
    // ties keep x first
    swap      = ax_v > ay_v;
    item.cur  = in_data.current_u;
    item.f    = in_data.inverse_speed;
    item.a0   = swap ? ay_v : ax_v;
    item.h0   = swap ? ay_h : ax_h;
    item.a1   = swap ? ax_v : ay_v;
    item.h1   = swap ? ax_h : ay_h;
    item.d    = item.a1 - item.a0;
    if (in_data.inverse_speed == VINF) begin
      item.kind = KIND_FIXED;
    end else if (ax_v == VINF && ay_v == VINF) begin
      item.kind = KIND_NONE;
    end else begin
      item.kind = KIND_SOLVE;
    end
  end

endmodule

>>> rtl/eik_queue.sv
// Short FIFO between the classifying front end and the solver pipeline.
// Depends on eik_pkg and assert_macros.svh.
`include "assert_macros.svh"
module eik_queue import eik_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  eik_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output eik_item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  eik_item_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push, pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `EIK_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH))
  `EIK_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1)
  `EIK_ASSERT_NEXT(a_count_down, clk, rst_n, pop && !push, count_r == $past(count_r) - 1'b1)

endmodule

>>> rtl/eik_mul.sv
// Two-stage multiplier built from registered 32 by 32 partial products.
// No dependencies.
module eik_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic [AW+BW-1:0] p
);

  localparam int CH  = 32;
  localparam int NA  = (AW + CH - 1) / CH;
  localparam int NB  = (BW + CH - 1) / CH;
  localparam int APW = NA * CH;
  localparam int BPW = NB * CH;
  localparam int PW  = AW + BW;

  logic [APW-1:0]  a_pad;
  logic [BPW-1:0]  b_pad;
  logic [2*CH-1:0] pp_r [NA*NB];
  logic [PW-1:0]   sum, p_r;

  assign a_pad = APW'(a);
  assign b_pad = BPW'(b);
  assign p     = p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i*NB+j] <= a_pad[i*CH +: CH] * b_pad[j*CH +: CH];
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (PW'(pp_r[i*NB+j]) << (CH * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sum;
    end
  end

endmodule

>>> rtl/eik_sqrt.sv
// Pipelined integer square root, one result bit per stage, floor rounding.
// No dependencies.
module eik_sqrt #(
  parameter int XW = 128,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [XW-1:0]   in_x,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [XW/2-1:0] out_root,
  output logic [SW-1:0]   out_side
);

  localparam int RW = XW / 2;
  localparam int MW = RW + 2;

  logic          vld_r  [RW];
  logic [MW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [XW-1:0] x_r    [RW];
  logic [SW-1:0] side_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic          v_in;
    logic [MW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [XW-1:0] x_in;
    logic [SW-1:0] s_in;
    logic [MW+1:0] acc, trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = in_x;
      assign s_in    = in_side;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign x_in    = x_r[k-1];
      assign s_in    = side_r[k-1];
    end

    // bring down the next two bits, trial divisor is 4*root + 1
    assign acc   = {rem_in, x_in[XW-1 -: 2]};
    assign trial = (MW+2)'({root_in, 2'b01});
    assign ge    = acc >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? MW'(acc - trial) : MW'(acc);
        root_r[k] <= {root_in[RW-2:0], ge};
        x_r[k]    <= x_in << 2;
        side_r[k] <= s_in;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

>>> rtl/eik_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Expects the starting remainder below the divisor; no dependencies.
module eik_div #(
  parameter int DW = 81,
  parameter int NQ = 32,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [NQ-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NQ-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [NQ];
  logic [DW-1:0] rem_r  [NQ];
  logic [NQ-1:0] nq_r   [NQ];
  logic [DW-1:0] den_r  [NQ];
  logic [SW-1:0] side_r [NQ];

  for (genvar k = 0; k < NQ; k++) begin : g_st
    logic          v_in;
    logic [DW-1:0] rem_in, den_in;
    logic [NQ-1:0] nq_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = in_rem;
      assign nq_in  = in_num;
      assign den_in = in_den;
      assign s_in   = in_side;
    end else begin : g_next
      assign v_in   = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign nq_in  = nq_r[k-1];
      assign den_in = den_r[k-1];
      assign s_in   = side_r[k-1];
    end

    // numerator bits leave at the top while quotient bits enter at the bottom
    assign t  = {rem_in, nq_in[NQ-1]};
    assign ge = t >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? DW'(t - {1'b0, den_in}) : DW'(t);
        nq_r[k]   <= {nq_in[NQ-2:0], ge};
        den_r[k]  <= den_in;
        side_r[k] <= s_in;
      end
    end
  end

  assign out_valid = vld_r[NQ-1];
  assign out_quot  = nq_r[NQ-1];
  assign out_side  = side_r[NQ-1];

endmodule

>>> rtl/eik_back.sv
// Solver pipeline: one-axis try, discriminant, root, quotient and final minimum.
// Depends on eik_pkg, eik_mul, eik_sqrt and eik_div.
module eik_back import eik_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  eik_item_t q_item,
  output logic      out_valid,
  input  logic      out_ready,
  output eik_out_t  out_data
);

  localparam int W   = VB;
  localparam int F   = FB;
  localparam int SW2 = 2*W + 1;
  localparam int QMW = 4*W + 1;
  localparam int QW  = 4*W;
  localparam int TW  = 2*W + 2*F;
  localparam int XW  = (QMW > TW) ? QMW : TW;
  localparam int DHW = 3*W;
  localparam int NW0 = (DHW + F > QW) ? DHW + F : QW;
  localparam int NW  = NW0 + 1;
  localparam int DW  = SW2 + F;
  localparam int HW  = NW - W;
  localparam int OW  = (HW > DW) ? HW : DW;

  typedef struct packed {
    logic [W-1:0] cur;
    logic [W-1:0] a0;
    logic         early;
    logic [W-1:0] early_val;
  } base_t;

  typedef struct packed {
    base_t          b;
    logic [2*W-1:0] ff;
    logic [2*W-1:0] h00;
    logic [2*W-1:0] h01;
    logic [2*W-1:0] dd;
    logic [SW2-1:0] s;
    logic [W-1:0]   d;
  } s2_t;

  typedef struct packed {
    base_t          b;
    logic [2*W-1:0] h01;
    logic [2*W-1:0] dd;
    logic [SW2-1:0] s;
  } s3_t;

  typedef struct packed {
    base_t          b;
    logic [2*W-1:0] h01;
    logic [DHW-1:0] dh;
    logic [SW2-1:0] s;
  } sq_side_t;

  typedef struct packed {
    sq_side_t      sd;
    logic [QW-1:0] qd;
  } s4_t;

  typedef struct packed {
    base_t          b;
    logic [DHW-1:0] dh;
    logic [SW2-1:0] s;
  } s5_t;

  typedef struct packed {
    base_t          b;
    logic [NW-1:0]  n;
    logic [SW2-1:0] s;
  } s6_t;

  typedef struct packed {
    base_t b;
    logic  ovf;
  } dv_side_t;

  logic adv;

  logic      s1a_vld_r, s1b_vld_r;
  eik_item_t s1a_r, s1b_r;
  logic [2*W-1:0] hf_p, h00_p, h11_p, h01_p, dd_p, ff_p;

  s2_t  s2_nxt, s2_r;
  logic s2_vld_r;
  logic [QMW-1:0] q_p;
  logic [DHW-1:0] dh_p;

  s3_t  s3a_r, s3b_r;
  logic s3a_vld_r, s3b_vld_r;

  s4_t  s4_nxt, s4_r;
  logic s4_vld_r;

  logic           sq_vld;
  logic [2*W-1:0] sq_root;
  sq_side_t       sq_side;

  logic [4*W-1:0] hr_p;
  s5_t  s5a_r, s5b_r;
  logic s5a_vld_r, s5b_vld_r;

  s6_t  s6_nxt, s6_r;
  logic s6_vld_r;

  logic [DW-1:0] dv_den;
  logic [HW-1:0] n_hi;
  dv_side_t      dv_side_in, dv_side;
  logic          dv_vld;
  logic [W-1:0]  dv_quot;

  eik_out_t out_nxt, out_data_r;
  logic     out_valid_r;

  // one global advance: the whole pipeline holds while the result waits
  assign adv       = !out_valid_r || out_ready;
  assign q_ready   = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- first products
  eik_mul #(.AW(W), .BW(W)) u_mul_hf  (.clk, .en(adv), .a(q_item.h0), .b(q_item.f),
                                       .p(hf_p));
  eik_mul #(.AW(W), .BW(W)) u_mul_h00 (.clk, .en(adv), .a(q_item.h0), .b(q_item.h0),
                                       .p(h00_p));
  eik_mul #(.AW(W), .BW(W)) u_mul_h11 (.clk, .en(adv), .a(q_item.h1), .b(q_item.h1),
                                       .p(h11_p));
  eik_mul #(.AW(W), .BW(W)) u_mul_h01 (.clk, .en(adv), .a(q_item.h0), .b(q_item.h1),
                                       .p(h01_p));
  eik_mul #(.AW(W), .BW(W)) u_mul_dd  (.clk, .en(adv), .a(q_item.d), .b(q_item.d),
                                       .p(dd_p));
  eik_mul #(.AW(W), .BW(W)) u_mul_ff  (.clk, .en(adv), .a(q_item.f), .b(q_item.f),
                                       .p(ff_p));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1a_vld_r <= 1'b0;
      s1b_vld_r <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3a_vld_r <= 1'b0;
      s3b_vld_r <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5a_vld_r <= 1'b0;
      s5b_vld_r <= 1'b0;
      s6_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1a_vld_r <= q_valid;
      s1b_vld_r <= s1a_vld_r;
      s2_vld_r  <= s1b_vld_r;
      s3a_vld_r <= s2_vld_r;
      s3b_vld_r <= s3a_vld_r;
      s4_vld_r  <= s3b_vld_r;
      s5a_vld_r <= sq_vld;
      s5b_vld_r <= s5a_vld_r;
      s6_vld_r  <= s5b_vld_r;
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1a_r      <= q_item;
      s1b_r      <= s1a_r;
      s2_r       <= s2_nxt;
      s3a_r      <= '{b: s2_r.b, h01: s2_r.h01, dd: s2_r.dd, s: s2_r.s};
      s3b_r      <= s3a_r;
      s4_r       <= s4_nxt;
      s5a_r      <= '{b: sq_side.b, dh: sq_side.dh, s: sq_side.s};
      s5b_r      <= s5a_r;
      s6_r       <= s6_nxt;
      out_data_r <= out_nxt;
    end
  end

  // ---- one-axis answer and early exits
  always_comb begin
    logic [2*W-1:0] c;
    logic [2*W-1:0] lim;
    logic [W-1:0]   u;
    logic           one_ok;
    c      = hf_p >> F;
    lim    = (2*W)'(VINF - s1b_r.a0);
    u      = (c >= lim) ? VINF : s1b_r.a0 + c[W-1:0];
    one_ok = u <= s1b_r.a1;
    s2_nxt.s     = SW2'(h00_p) + SW2'(h11_p);
    s2_nxt.b.cur = s1b_r.cur;
    s2_nxt.b.a0  = s1b_r.a0;
    s2_nxt.b.early = (s1b_r.kind != KIND_SOLVE) || one_ok || (s2_nxt.s == '0);
    if (s1b_r.kind == KIND_FIXED) begin
      s2_nxt.b.early_val = s1b_r.cur;
    end else if (s1b_r.kind == KIND_NONE) begin
      s2_nxt.b.early_val = VINF;
    end else if (one_ok) begin
      s2_nxt.b.early_val = u;
    end else begin
      s2_nxt.b.early_val = s1b_r.a0;
    end
    s2_nxt.ff  = ff_p;
    s2_nxt.h00 = h00_p;
    s2_nxt.h01 = h01_p;
    s2_nxt.dd  = dd_p;
    s2_nxt.d   = s1b_r.d;
  end

  // ---- discriminant products
  eik_mul #(.AW(2*W), .BW(SW2)) u_mul_q  (.clk, .en(adv), .a(s2_r.ff), .b(s2_r.s),
                                          .p(q_p));
  eik_mul #(.AW(W), .BW(2*W))   u_mul_dh (.clk, .en(adv), .a(s2_r.d), .b(s2_r.h00),
                                          .p(dh_p));

  // clamp a negative discriminant to zero
  always_comb begin
    logic [XW-1:0] qx, tx;
    qx = XW'(q_p);
    tx = XW'(s3b_r.dd) << (2*F);
    s4_nxt.qd    = (qx >= tx) ? QW'(qx - tx) : '0;
    s4_nxt.sd.b  = s3b_r.b;
    s4_nxt.sd.h01 = s3b_r.h01;
    s4_nxt.sd.dh = dh_p;
    s4_nxt.sd.s  = s3b_r.s;
  end

  eik_sqrt #(.XW(QW), .SW($bits(sq_side_t))) u_sqrt (
    .clk,
    .rst_n,
    .en       (adv),
    .in_valid (s4_vld_r),
    .in_x     (s4_r.qd),
    .in_side  (s4_r.sd),
    .out_valid(sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  eik_mul #(.AW(2*W), .BW(2*W)) u_mul_hr (.clk, .en(adv), .a(sq_side.h01), .b(sq_root),
                                          .p(hr_p));

  always_comb begin
    s6_nxt.b = s5b_r.b;
    s6_nxt.n = (NW'(s5b_r.dh) << F) + NW'(hr_p);
    s6_nxt.s = s5b_r.s;
  end

  // quotient bits above the value width mean saturation
  always_comb begin
    dv_den = DW'(s6_r.s) << F;
    n_hi   = s6_r.n[NW-1:W];
    dv_side_in.b   = s6_r.b;
    dv_side_in.ovf = OW'(n_hi) >= OW'(dv_den);
  end

  eik_div #(.DW(DW), .NQ(W), .SW($bits(dv_side_t))) u_div (
    .clk,
    .rst_n,
    .en       (adv),
    .in_valid (s6_vld_r),
    .in_rem   (DW'(n_hi)),
    .in_num   (s6_r.n[W-1:0]),
    .in_den   (dv_den),
    .in_side  (dv_side_in),
    .out_valid(dv_vld),
    .out_quot (dv_quot),
    .out_side (dv_side)
  );

  always_comb begin
    logic [W-1:0] solved;
    logic [W-1:0] qlim;
    logic [W-1:0] nu;
    qlim = VINF - dv_side.b.a0;
    if (dv_side.b.early) begin
      solved = dv_side.b.early_val;
    end else if (dv_side.ovf || dv_quot >= qlim) begin
      solved = VINF;
    end else begin
      solved = dv_side.b.a0 + dv_quot;
    end
    nu = (solved < dv_side.b.cur) ? solved : dv_side.b.cur;
    out_nxt.new_u    = nu;
    out_nxt.decrease = dv_side.b.cur - nu;
  end

endmodule

>>> rtl/eikonal_node_update_top.sv
// Eikonal node update, 2D upwind solver in unsigned Q16.16 with all ones as infinity.
// Takes one grid node per clock while the output does not stall and returns one
// updated value per node, in order. Each accepted node passes through the queue,
// then a fully pipelined solver whose length is set by the 64-stage square root of
// the discriminant and the 32-stage divider for the two-axis root, plus two-stage
// multipliers. Sustained rate is one node per cycle; a stall at the output holds the
// solver while the queue keeps taking up to QUEUE_DEPTH nodes.
// Depends on eik_pkg, eik_front, eik_queue and eik_back.
module eikonal_node_update_top import eik_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  eik_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output eik_out_t out_data
);

  eik_item_t fr_item, q_item;
  logic      q_valid, q_ready;

  eik_front u_front (
    .in_data,
    .item(fr_item)
  );

  eik_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk,
    .rst_n,
    .push_valid(in_valid),
    .push_ready(in_ready),
    .push_item (fr_item),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_item  (q_item)
  );

  eik_back u_back (
    .clk,
    .rst_n,
    .q_valid,
    .q_ready,
    .q_item,
    .out_valid,
    .out_ready,
    .out_data
  );

endmodule
